FILE: rtl/slfr_pkg.sv
// shared types and constants for the sync length frame receiver
// no dependencies

package slfr_pkg;

   localparam logic [7:0]  SYNC_A      = 8'hAA;
   localparam logic [7:0]  SYNC_B      = 8'h55;
   localparam logic [15:0] SHORT_LIMIT = 16'd13;
   localparam logic [4:0]  FIRST_SEG   = 5'd14;
   localparam logic [4:0]  FULL_SEG    = 5'd16;
   localparam logic [15:0] MAX_LENGTH_RESET = 16'd255;

   typedef enum logic [2:0] {
      PH_SYNC0 = 3'd0,
      PH_SYNC1 = 3'd1,
      PH_LENHI = 3'd2,
      PH_LENLO = 3'd3,
      PH_DATA  = 3'd4,
      PH_CHECK = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_SYNC0   = 3'd1,
      ST_SYNC1   = 3'd2,
      ST_LONG    = 3'd3,
      ST_CHECK   = 3'd4,
      ST_TIMEOUT = 3'd5
   } status_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        data_valid;
      logic        segment_end;
      logic        frame_end;
      status_type  status;
      logic [15:0] frame_length;
   } result_type;

endpackage

FILE: rtl/sync_length_frame_receiver.sv
// sync length frame receiver: parses sync / length / payload / check frames
// from a byte stream, one beat per cycle
// depends on slfr_pkg
//
// usage:
//   req channel: one beat per link byte (req_kind 0) or ready-wait timeout
//   event (req_kind 1). rsp channel: exactly one result beat per req beat,
//   in order. csr_write_en/csr_write_data load max_length (reset 255); write
//   only while no beat is in flight.
//   each result is registered in the result register that drives rsp.
//   throughput: one beat per cycle; the frame state update is a single
//   combinational pass between the state registers and the result register.
//   a new beat is taken while the result register is empty or being drained.
//   stall: when rsp_ready is low with a result held, req_ready drops and the
//   held result stays unchanged until taken.
//   reset: result register emptied, parser back to waiting for the first
//   sync byte, max_length back to 255.

module sync_length_frame_receiver (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_data_valid,
   output logic        rsp_segment_end,
   output logic        rsp_frame_end,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_frame_length,
   input  logic        csr_write_en,
   input  logic [15:0] csr_write_data
);

   slfr_pkg::phase_type  phase_ff, phase_in;
   logic [7:0]           first_sync_ff, first_sync_in;
   logic [7:0]           length_high_ff, length_high_in;
   logic [15:0]          total_length_ff, total_length_in;
   logic [15:0]          remaining_ff, remaining_in;
   logic [7:0]           running_xor_ff, running_xor_in;
   logic [4:0]           segment_count_ff, segment_count_in;
   logic [15:0]          max_length_ff;
   logic                 rsp_valid_ff;
   slfr_pkg::result_type result_ff, result_in;

   logic                 accept;
   logic [15:0]          len;
   logic [15:0]          rem_dec;
   logic [4:0]           seg_dec;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign len       = {length_high_ff, req_rx_byte};
   assign rem_dec   = (remaining_ff != 16'd0) ? remaining_ff - 16'd1 : remaining_ff;
   assign seg_dec   = segment_count_ff - 5'd1;

   always_comb begin
      phase_in         = phase_ff;
      first_sync_in    = first_sync_ff;
      length_high_in   = length_high_ff;
      total_length_in  = total_length_ff;
      remaining_in     = remaining_ff;
      running_xor_in   = running_xor_ff;
      segment_count_in = segment_count_ff;
      result_in        = '0;
      result_in.status = slfr_pkg::ST_OK;

      if (req_kind) begin
         // timeout aborts a frame in progress, ignored while idle
         if (phase_ff != slfr_pkg::PH_SYNC0) begin
            result_in.frame_end    = 1'b1;
            result_in.status       = slfr_pkg::ST_TIMEOUT;
            result_in.frame_length = total_length_ff;
            phase_in               = slfr_pkg::PH_SYNC0;
         end
      end else begin
         case (phase_ff)
            slfr_pkg::PH_SYNC0: begin
               first_sync_in   = req_rx_byte;
               total_length_in = 16'd0;
               phase_in        = slfr_pkg::PH_SYNC1;
            end
            slfr_pkg::PH_SYNC1: begin
               result_in.segment_end = 1'b1;
               if (first_sync_ff != slfr_pkg::SYNC_A) begin
                  result_in.frame_end    = 1'b1;
                  result_in.status       = slfr_pkg::ST_SYNC0;
                  result_in.frame_length = total_length_ff;
                  phase_in               = slfr_pkg::PH_SYNC0;
               end else if (req_rx_byte != slfr_pkg::SYNC_B) begin
                  result_in.frame_end    = 1'b1;
                  result_in.status       = slfr_pkg::ST_SYNC1;
                  result_in.frame_length = total_length_ff;
                  phase_in               = slfr_pkg::PH_SYNC0;
               end else begin
                  phase_in = slfr_pkg::PH_LENHI;
               end
            end
            slfr_pkg::PH_LENHI: begin
               length_high_in = req_rx_byte;
               phase_in       = slfr_pkg::PH_LENLO;
            end
            slfr_pkg::PH_LENLO: begin
               total_length_in = len;
               if (len > max_length_ff) begin
                  result_in.frame_end    = 1'b1;
                  result_in.status       = slfr_pkg::ST_LONG;
                  result_in.frame_length = len;
                  phase_in               = slfr_pkg::PH_SYNC0;
               end else begin
                  remaining_in     = len;
                  running_xor_in   = 8'd0;
                  segment_count_in = (len <= slfr_pkg::SHORT_LIMIT) ? 5'd0
                                                                    : slfr_pkg::FIRST_SEG;
                  phase_in         = (len == 16'd0) ? slfr_pkg::PH_CHECK
                                                    : slfr_pkg::PH_DATA;
               end
            end
            slfr_pkg::PH_DATA: begin
               result_in.data_byte  = req_rx_byte;
               result_in.data_valid = 1'b1;
               running_xor_in       = running_xor_ff ^ req_rx_byte;
               remaining_in         = rem_dec;
               if (segment_count_ff != 5'd0) begin
                  segment_count_in = seg_dec;
                  if (seg_dec == 5'd0) begin
                     result_in.segment_end = 1'b1;
                     segment_count_in = (rem_dec >= 16'(slfr_pkg::FULL_SEG))
                                        ? slfr_pkg::FULL_SEG : 5'd0;
                  end
               end
               if (rem_dec == 16'd0) begin
                  phase_in = slfr_pkg::PH_CHECK;
               end
            end
            slfr_pkg::PH_CHECK: begin
               result_in.segment_end  = 1'b1;
               result_in.frame_end    = 1'b1;
               result_in.status       = (req_rx_byte == ~running_xor_ff) ? slfr_pkg::ST_OK
                                                                        : slfr_pkg::ST_CHECK;
               result_in.frame_length = total_length_ff;
               phase_in               = slfr_pkg::PH_SYNC0;
            end
            default: begin
               phase_in = slfr_pkg::PH_SYNC0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= slfr_pkg::PH_SYNC0;
         first_sync_ff    <= 8'd0;
         length_high_ff   <= 8'd0;
         total_length_ff  <= 16'd0;
         remaining_ff     <= 16'd0;
         running_xor_ff   <= 8'd0;
         segment_count_ff <= 5'd0;
         max_length_ff    <= slfr_pkg::MAX_LENGTH_RESET;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_write_en) begin
            max_length_ff <= csr_write_data;
         end
         if (accept) begin
            phase_ff         <= phase_in;
            first_sync_ff    <= first_sync_in;
            length_high_ff   <= length_high_in;
            total_length_ff  <= total_length_in;
            remaining_ff     <= remaining_in;
            running_xor_ff   <= running_xor_in;
            segment_count_ff <= segment_count_in;
            rsp_valid_ff     <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload, loaded on each accepted beat
   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data_byte    = result_ff.data_byte;
   assign rsp_data_valid   = result_ff.data_valid;
   assign rsp_segment_end  = result_ff.segment_end;
   assign rsp_frame_end    = result_ff.frame_end;
   assign rsp_status       = result_ff.status;
   assign rsp_frame_length = result_ff.frame_length;

   // result register empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat present after reset");

   // a held result blocks new beats
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("beat accepted while result stalled");

   // an error status only comes with the end of a frame
   a_error_ends_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != 3'(slfr_pkg::ST_OK)) |-> rsp_frame_end)
      else $error("error status without frame end");

   // a payload byte never closes a frame
   a_data_not_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data_valid) |-> !rsp_frame_end)
      else $error("payload byte marked as frame end");

endmodule

FILE: tb/tb_top.sv
// testbench for sync_length_frame_receiver: random framed byte streams with
// sync, length, check and timeout faults, checked beat by beat against a frame tracker
// depends on slfr_pkg and the sync_length_frame_receiver rtl
`timescale 1ns / 100ps

module tb_top;

   localparam logic KIND_BYTE    = 1'b0;
   localparam logic KIND_TIMEOUT = 1'b1;
   localparam int   QUIET_LIMIT  = 1000;
   localparam int   HOLD_CYCLES  = 64;
   localparam int   PHASE_BEATS  = 100;

   class frame_tracker;
      slfr_pkg::result_type due_results[$];
      int                   errors;
      int                   checked;
      logic [15:0]          frame_limit;
      slfr_pkg::phase_type  parse_phase;
      logic [7:0]           first_sync;
      logic [7:0]           length_high;
      logic [15:0]          total_length;
      logic [15:0]          remaining;
      logic [7:0]           running_xor;
      logic [4:0]           seg_left;

      function new();
         errors       = 0;
         checked      = 0;
         frame_limit  = slfr_pkg::MAX_LENGTH_RESET;
         parse_phase  = slfr_pkg::PH_SYNC0;
         first_sync   = '0;
         length_high  = '0;
         total_length = '0;
         remaining    = '0;
         running_xor  = '0;
         seg_left     = '0;
      endfunction

      function void set_limit(logic [15:0] value);
         frame_limit = value;
      endfunction

      function void close_frame(inout slfr_pkg::result_type r,
                                input slfr_pkg::status_type code);
         r.frame_end    = 1'b1;
         r.status       = code;
         r.frame_length = total_length;
         parse_phase    = slfr_pkg::PH_SYNC0;
      endfunction

      function void note_beat(logic kind, logic [7:0] b);
         slfr_pkg::result_type r;
         logic [15:0]          len;
         r = '0;
         if (kind == KIND_TIMEOUT) begin
            if (parse_phase != slfr_pkg::PH_SYNC0) close_frame(r, slfr_pkg::ST_TIMEOUT);
         end else begin
            case (parse_phase)
               slfr_pkg::PH_SYNC0: begin
                  first_sync   = b;
                  total_length = '0;
                  parse_phase  = slfr_pkg::PH_SYNC1;
               end
               slfr_pkg::PH_SYNC1: begin
                  r.segment_end = 1'b1;
                  if (first_sync != slfr_pkg::SYNC_A) close_frame(r, slfr_pkg::ST_SYNC0);
                  else if (b != slfr_pkg::SYNC_B) close_frame(r, slfr_pkg::ST_SYNC1);
                  else parse_phase = slfr_pkg::PH_LENHI;
               end
               slfr_pkg::PH_LENHI: begin
                  length_high = b;
                  parse_phase = slfr_pkg::PH_LENLO;
               end
               slfr_pkg::PH_LENLO: begin
                  len          = {length_high, b};
                  total_length = len;
                  if (len > frame_limit) begin
                     close_frame(r, slfr_pkg::ST_LONG);
                  end else begin
                     remaining   = len;
                     running_xor = '0;
                     seg_left    = (len <= slfr_pkg::SHORT_LIMIT) ? 5'd0 : slfr_pkg::FIRST_SEG;
                     parse_phase = (len == 16'd0) ? slfr_pkg::PH_CHECK : slfr_pkg::PH_DATA;
                  end
               end
               slfr_pkg::PH_DATA: begin
                  r.data_byte  = b;
                  r.data_valid = 1'b1;
                  running_xor  = running_xor ^ b;
                  if (remaining != 16'd0) remaining = remaining - 16'd1;
                  if (seg_left != 5'd0) begin
                     seg_left = seg_left - 5'd1;
                     if (seg_left == 5'd0) begin
                        r.segment_end = 1'b1;
                        seg_left = (remaining >= 16'(slfr_pkg::FULL_SEG))
                                   ? slfr_pkg::FULL_SEG : 5'd0;
                     end
                  end
                  if (remaining == 16'd0) parse_phase = slfr_pkg::PH_CHECK;
               end
               slfr_pkg::PH_CHECK: begin
                  r.segment_end = 1'b1;
                  close_frame(r, (b == ~running_xor) ? slfr_pkg::ST_OK : slfr_pkg::ST_CHECK);
               end
               default: begin
                  parse_phase = slfr_pkg::PH_SYNC0;
               end
            endcase
         end
         due_results.push_back(r);
      endfunction

      task report(string field, int unsigned got, int unsigned want);
         $display("mismatch at result %0d, %s: got %0h, expected %0h",
                  checked, field, got, want);
         errors++;
      endtask

      task check_result(slfr_pkg::result_type got);
         slfr_pkg::result_type want;
         if (due_results.size() == 0) begin
            report("no result due", 0, 0);
            return;
         end
         want = due_results.pop_front();
         checked++;
         if (got.data_byte !== want.data_byte)
            report("data_byte", got.data_byte, want.data_byte);
         if (got.data_valid !== want.data_valid)
            report("data_valid", got.data_valid, want.data_valid);
         if (got.segment_end !== want.segment_end)
            report("segment_end", got.segment_end, want.segment_end);
         if (got.frame_end !== want.frame_end)
            report("frame_end", got.frame_end, want.frame_end);
         if (got.status !== want.status)
            report("status", got.status, want.status);
         if (got.frame_length !== want.frame_length)
            report("frame_length", got.frame_length, want.frame_length);
      endtask
   endclass

   logic        clock;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_ready;
   logic        req_kind       = 1'b0;
   logic [7:0]  req_rx_byte    = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready      = 1'b0;
   logic [7:0]  rsp_data_byte;
   logic        rsp_data_valid;
   logic        rsp_segment_end;
   logic        rsp_frame_end;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_frame_length;
   logic        csr_write_en   = 1'b0;
   logic [15:0] csr_write_data = 16'h0000;

   frame_tracker         tracker;
   slfr_pkg::result_type seen;
   logic [15:0]          cur_limit      = slfr_pkg::MAX_LENGTH_RESET;
   bit                   send_idle_on   = 1'b0;
   bit                   recv_idle_on   = 1'b0;
   bit                   hold_request   = 1'b0;
   int                   beats_sent     = 0;
   int                   quiet_cycles   = 0;

   sync_length_frame_receiver u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_data_valid   (rsp_data_valid),
      .rsp_segment_end  (rsp_segment_end),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_status       (rsp_status),
      .rsp_frame_length (rsp_frame_length),
      .csr_write_en     (csr_write_en),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned pick_gap();
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 30);
      return $urandom_range(1, 3);
   endfunction

   function automatic logic [15:0] pick_length();
      int unsigned r;
      int unsigned n;
      r = $urandom_range(0, 99);
      if (r < 60) n = $urandom_range(0, 20);
      else if (r < 90) n = $urandom_range(21, 60);
      else n = $urandom_range(61, 200);
      return 16'(n % (int'(cur_limit) + 1));
   endfunction

   task automatic send_beat(input logic kind, input logic [7:0] b);
      if (send_idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat (pick_gap()) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_kind    <= kind;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_beat(kind, b);
      beats_sent++;
   endtask

   task automatic write_limit(input logic [15:0] value);
      req_valid <= 1'b0;
      while (tracker.due_results.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      tracker.set_limit(value);
      cur_limit = value;
   endtask

   task automatic send_frame();
      logic [7:0]  frame_bytes[$];
      logic [7:0]  parity;
      logic [7:0]  b;
      logic [15:0] len;
      int unsigned mode;
      int unsigned body;
      int unsigned count;
      int unsigned i;
      bit          abort;
      mode  = $urandom_range(0, 19);
      abort = 1'b0;
      // noise, then a timeout to get back in step
      if (mode == 19) begin
         repeat ($urandom_range(1, 3)) send_beat(1'($urandom_range(0, 1)), 8'($urandom));
         send_beat(KIND_TIMEOUT, 8'($urandom));
         return;
      end
      len = pick_length();
      if (mode == 18 && cur_limit != 16'hFFFF)
         len = 16'($urandom_range(32'hFFFF, int'(cur_limit) + 1));
      else if (mode == 17 && cur_limit == 16'hFFFF && $urandom_range(0, 1) == 1)
         len = 16'hFFFF;
      if (len > cur_limit) body = 0;
      else if (mode == 17 && len > 40) body = 40;
      else body = len;
      frame_bytes.push_back(slfr_pkg::SYNC_A);
      frame_bytes.push_back(slfr_pkg::SYNC_B);
      frame_bytes.push_back(len[15:8]);
      frame_bytes.push_back(len[7:0]);
      parity = 8'h00;
      repeat (body) begin
         b = 8'($urandom);
         parity = parity ^ b;
         frame_bytes.push_back(b);
      end
      if (len <= cur_limit && body == len)
         frame_bytes.push_back(~parity ^ ((mode == 14) ? 8'($urandom_range(1, 255)) : 8'h00));
      count = frame_bytes.size();
      if (mode == 15) begin
         frame_bytes[0] = frame_bytes[0] ^ 8'($urandom_range(1, 255));
         count = 2;
      end else if (mode == 16) begin
         frame_bytes[1] = frame_bytes[1] ^ 8'($urandom_range(1, 255));
         count = 2;
      end else if (mode == 17) begin
         count = $urandom_range(1, frame_bytes.size() - 1);
         abort = 1'b1;
      end
      for (i = 0; i < count; i++) send_beat(KIND_BYTE, frame_bytes[i]);
      if (abort) send_beat(KIND_TIMEOUT, 8'($urandom));
   endtask

   // receiver side
   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (recv_idle_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat (pick_gap()) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen.data_byte    = rsp_data_byte;
         seen.data_valid   = rsp_data_valid;
         seen.segment_end  = rsp_segment_end;
         seen.frame_end    = rsp_frame_end;
         seen.status       = slfr_pkg::status_type'(rsp_status);
         seen.frame_length = rsp_frame_length;
         tracker.check_result(seen);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      logic [8:0]  opening[23];
      logic [15:0] limits[6];
      bit          send_idle_plan[6];
      bit          recv_idle_plan[6];
      int          p;
      int          i;
      tracker = new();
      // idle timeout, bad first sync, bad second sync, empty frame, too long,
      // bad check, timeout before the length
      opening = '{{KIND_TIMEOUT, 8'hFF},
                  {KIND_BYTE, 8'h00}, {KIND_BYTE, slfr_pkg::SYNC_B},
                  {KIND_BYTE, slfr_pkg::SYNC_A}, {KIND_BYTE, 8'hFF},
                  {KIND_BYTE, slfr_pkg::SYNC_A}, {KIND_BYTE, slfr_pkg::SYNC_B},
                  {KIND_BYTE, 8'h00}, {KIND_BYTE, 8'h00}, {KIND_BYTE, 8'hFF},
                  {KIND_BYTE, slfr_pkg::SYNC_A}, {KIND_BYTE, slfr_pkg::SYNC_B},
                  {KIND_BYTE, 8'h01}, {KIND_BYTE, 8'h00},
                  {KIND_BYTE, slfr_pkg::SYNC_A}, {KIND_BYTE, slfr_pkg::SYNC_B},
                  {KIND_BYTE, 8'h00}, {KIND_BYTE, 8'h01}, {KIND_BYTE, 8'h00},
                  {KIND_BYTE, 8'h00},
                  {KIND_BYTE, slfr_pkg::SYNC_A}, {KIND_BYTE, slfr_pkg::SYNC_B},
                  {KIND_TIMEOUT, 8'h00}};
      limits         = '{16'd0, 16'hFFFF, 16'd13, 16'd14, 16'd40,
                         16'($urandom_range(15, 300))};
      send_idle_plan = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
      recv_idle_plan = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (i = 0; i < 23; i++) send_beat(opening[i][8], opening[i][7:0]);
      for (p = 0; p < 6; p++) begin
         write_limit(limits[p]);
         send_idle_on = send_idle_plan[p];
         recv_idle_on = recv_idle_plan[p];
         if (p == 1 || p == 4) hold_request = 1'b1;
         while (beats_sent < 23 + (p + 1) * PHASE_BEATS) send_frame();
      end
      req_valid <= 1'b0;
      while (tracker.due_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
